// ===== hdl/varint_stream_decoder_top_assert.svh =====
// assertion macros for the varint stream decoder checker
`ifndef VARINT_STREAM_DECODER_TOP_ASSERT_SVH
`define VARINT_STREAM_DECODER_TOP_ASSERT_SVH

// same-cycle implication, inactive during reset
`define VSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vsd assertion failed");

// next-cycle implication, inactive during reset
`define VSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vsd assertion failed");

// checked at every edge, reset included
`define VSD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) (cond)) \
        else $error("vsd assertion failed");

`endif

// ===== hdl/vsd_pkg.sv =====
`default_nettype none

package vsd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PAYLOAD_W   = 7;
    localparam int unsigned ACC_W       = 64;
    localparam int unsigned SHIFT_W     = 6;
    localparam int unsigned BITS_PER_BYTE = 7;
    localparam int unsigned MORE_BIT    = 7;

    typedef enum logic [1:0] {
        ST_NEED_MORE = 2'd0,
        ST_DONE      = 2'd1,
        ST_TOO_MANY  = 2'd2
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              is_signed;
    } in_item_t;

endpackage

`default_nettype wire

// ===== hdl/vsd_if.sv =====
`default_nettype none

interface vsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_signed;

    modport source (output valid, output data_byte, output is_signed, input ready);
    modport sink   (input valid, input data_byte, input is_signed, output ready);
endinterface

interface vsd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] value;

    modport source (output valid, output status, output value, input ready);
    modport sink   (input valid, input status, input value, output ready);
endinterface

`default_nettype wire

// ===== hdl/vsd_input_stage.sv =====
`default_nettype none

module vsd_input_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire vsd_pkg::in_item_t in_item,
    input  wire logic              take,
    output logic                   item_valid,
    output vsd_pkg::in_item_t      item
);
    import vsd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    always_comb
    begin
        in_ready   = !valid_reg || take;
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== hdl/vsd_decode.sv =====
`default_nettype none

module vsd_decode #(
    parameter int unsigned MAX_BYTES = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire vsd_pkg::in_item_t item,
    output logic                   take,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output vsd_pkg::status_t       out_status,
    output logic [63:0]            out_value
);
    import vsd_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_BYTES + 1);

    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic               valid_reg;
    logic               valid_next;
    status_t            status_reg;
    status_t            status_next;
    logic [ACC_W-1:0]   value_reg;
    logic [ACC_W-1:0]   value_next;

    logic [ACC_W-1:0]   base;
    logic [ACC_W-1:0]   part;
    logic [ACC_W-1:0]   merged;
    logic [ACC_W-1:0]   mag;
    logic [SHIFT_W-1:0] shift_amt;
    logic               fire;

    always_comb
    begin
        take  = !valid_reg || out_ready;
        fire  = item_valid && take;

        base      = (idx_reg == '0) ? '0 : acc_reg;
        shift_amt = SHIFT_W'(32'(idx_reg) * BITS_PER_BYTE);
        part      = {{(ACC_W-PAYLOAD_W){1'b0}}, item.data_byte[PAYLOAD_W-1:0]};
        merged    = base | (part << shift_amt);
        mag       = {merged[ACC_W-1], merged[ACC_W-1:1]};

        acc_next    = acc_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        value_next  = value_reg;
        valid_next  = take ? item_valid : valid_reg;

        if (fire)
        begin
            if (idx_reg >= IDX_W'(MAX_BYTES))
            begin
                // overlong value: drop it and start over
                acc_next    = '0;
                idx_next    = '0;
                status_next = ST_TOO_MANY;
                value_next  = '0;
            end
            else if (item.data_byte[MORE_BIT])
            begin
                acc_next    = merged;
                idx_next    = idx_reg + IDX_W'(1);
                status_next = ST_NEED_MORE;
                value_next  = merged;
            end
            else
            begin
                acc_next    = '0;
                idx_next    = '0;
                status_next = ST_DONE;
                if (item.is_signed)
                begin
                    value_next = merged[0] ? (ACC_W'(0) - mag) : mag;
                end
                else
                begin
                    value_next = merged;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_value  = value_reg;

endmodule

`default_nettype wire

// ===== hdl/varint_stream_decoder_top.sv =====
// channel   dir  payload                       handshake
// in_ch     in   data_byte[7:0], is_signed     valid/ready
// out_ch    out  status[1:0], value[63:0]      valid/ready
//
// one item per cycle sustained while the result side is not stalled, one result per item
// an item passes the input register, then is decoded into the result register
// rst_n clears the accumulator, byte count and both valid flags
// a stalled result holds; a new item is still taken while the input register is free

`default_nettype none

module varint_stream_decoder_top #(
    parameter int unsigned MAX_BYTES = 10
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    vsd_in_if.sink     in_ch,
    vsd_out_if.source  out_ch
);
    import vsd_pkg::*;

    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     take;
    status_t  out_status;

    assign in_item.data_byte = in_ch.data_byte;
    assign in_item.is_signed = in_ch.is_signed;

    vsd_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    vsd_decode #(
        .MAX_BYTES (MAX_BYTES)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .out_status (out_status),
        .out_value  (out_ch.value)
    );

    assign out_ch.status = out_status;

endmodule

`default_nettype wire

// ===== hdl/vsd_checker.sv =====
`default_nettype none

`include "varint_stream_decoder_top_assert.svh"

module vsd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [63:0] value
);
    import vsd_pkg::*;

    // a stalled result holds its payload
    `VSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(value))

    // input side only backs up when the result side is stalled
    `VSD_ASSERT_NOW(a_in_backpressure, !in_ready, out_valid && !out_ready)

    // an overlong value reports zero
    `VSD_ASSERT_NOW(a_err_zero, out_valid && (status == ST_TOO_MANY), value == 64'd0)

    // no result while in reset
    `VSD_ASSERT_ALWAYS(a_reset_quiet, rst_n || !out_valid)

endmodule

bind varint_stream_decoder_top vsd_checker u_vsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (out_ch.status),
    .value     (out_ch.value)
);

`default_nettype wire
